[rtl/core/llcqa_pkg.sv]
package llcqa_pkg;

	typedef enum logic [1:0] {
		SEQ_IDLE,
		SEQ_SCAN,
		SEQ_UPDATE,
		SEQ_DONE
	} seq_state_t;

	localparam logic [1:0] MODE_LEAST  = 2'd0;
	localparam logic [1:0] MODE_ASSIGN = 2'd1;
	localparam logic [1:0] MODE_REMOVE = 2'd2;
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_RANGE = 2'd1;
	localparam logic [1:0] STATUS_ZERO  = 2'd2;
	localparam logic [1:0] STATUS_FULL  = 2'd3;

	localparam logic REG_RANGE_FIRST = 1'b0;
	localparam logic REG_RANGE_LAST  = 1'b1;

	localparam int CPU_FIELD_W   = 6;
	localparam int COUNT_FIELD_W = 10;

endpackage

[rtl/core/llcqa_ram.sv]
module llcqa_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[rtl/core/least_loaded_cpu_queue_assigner_top.sv]
// Balanced assign scans every counter in the range, then updates the least loaded one.
// Named assign or remove reads one counter, then updates it; rejected words go straight to the result.
// One word in flight; the scan reads one counter per cycle through a single RAM read port.
// A new word is taken only once the previous result has moved into the output register.
// Reset clears the per-CPU valid bits, so every count reads as zero; range resets to 0..63.
module least_loaded_cpu_queue_assigner_top #(
	parameter int CPU_COUNT          = 64,
	parameter int MAX_QUEUES_PER_CPU = 1023
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  mode,
	input  logic [5:0]  cpu_number,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [5:0]  chosen_cpu,
	output logic [9:0]  new_count,
	output logic [1:0]  status,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	import llcqa_pkg::*;

	localparam int CPU_W = $clog2(CPU_COUNT);
	localparam int CNT_W = $clog2(MAX_QUEUES_PER_CPU + 1);
	localparam int IW    = (CPU_W > CPU_FIELD_W) ? CPU_W + 1 : CPU_FIELD_W + 1;
	localparam logic [IW-1:0]    LAST_CPU  = IW'(CPU_COUNT - 1);
	localparam logic [IW-1:0]    CPU_LIMIT = IW'(CPU_COUNT);
	localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(MAX_QUEUES_PER_CPU);

	seq_state_t state_q, state_d;

	logic [5:0]           range_first_q, range_last_q;
	logic [CPU_COUNT-1:0] valid_q;
	logic [1:0]           mode_q;
	logic [CPU_W-1:0]     idx_q, end_q, best_q;
	logic [CNT_W-1:0]     best_cnt_q;
	logic                 first_q, rdv_q;
	logic [5:0]           res_cpu_q;
	logic [9:0]           res_cnt_q;
	logic [1:0]           res_st_q;
	logic                 out_valid_q;
	logic [5:0]           out_cpu_q;
	logic [9:0]           out_cnt_q;
	logic [1:0]           out_st_q;

	logic                 cfg_we, in_fire, out_free;
	logic [IW-1:0]        first_ext, last_ext, eff_last, cpu_ext;
	logic                 range_empty, target_in_span, named_ok;
	logic [CPU_W-1:0]     first_idx, eff_last_idx, cpu_idx;
	logic                 ram_re, ram_we;
	logic [CPU_W-1:0]     ram_raddr;
	logic [CNT_W-1:0]     ram_rdata, cur_cnt, upd_cnt;
	logic                 take, inc, upd_ok;
	logic [CPU_W+5:0]     best_wide;
	logic [CNT_W+9:0]     cnt_wide;

	// configuration port
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_first_q <= 6'd0;
			range_last_q  <= 6'd63;
		end else if (cfg_we) begin
			if (paddr[2] == REG_RANGE_FIRST) begin
				range_first_q <= pwdata[5:0];
			end else begin
				range_last_q <= pwdata[5:0];
			end
		end
	end

	always_comb begin
		if (paddr[2] == REG_RANGE_LAST) begin
			prdata = {26'd0, range_last_q};
		end else begin
			prdata = {26'd0, range_first_q};
		end
	end

	// range decode
	assign first_ext    = IW'(range_first_q);
	assign last_ext     = IW'(range_last_q);
	assign eff_last     = (last_ext > LAST_CPU) ? LAST_CPU : last_ext;
	assign cpu_ext      = IW'(cpu_number);
	assign range_empty  = first_ext > eff_last;
	assign target_in_span = (cpu_ext >= first_ext) && (cpu_ext <= eff_last) &&
		(cpu_ext < CPU_LIMIT);
	assign named_ok     = (mode != MODE_LEAST) && (mode != MODE_UNUSED) && target_in_span;
	assign first_idx    = first_ext[CPU_W-1:0];
	assign eff_last_idx = eff_last[CPU_W-1:0];
	assign cpu_idx      = cpu_ext[CPU_W-1:0];

	assign in_ready = (state_q == SEQ_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// shared compare and step unit
	assign cur_cnt = rdv_q ? ram_rdata : '0;
	assign take    = first_q || (cur_cnt < best_cnt_q);
	assign inc     = (mode_q != MODE_REMOVE);
	assign upd_ok  = inc ? (best_cnt_q != CNT_MAX) : (best_cnt_q != '0);
	assign upd_cnt = inc ? best_cnt_q + 1'b1 : best_cnt_q - 1'b1;

	assign best_wide = {6'd0, best_q};
	assign cnt_wide  = {10'd0, upd_ok ? upd_cnt : best_cnt_q};

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			SEQ_IDLE: begin
				if (in_fire) begin
					if (mode == MODE_LEAST) begin
						state_d = range_empty ? SEQ_DONE : SEQ_SCAN;
					end else begin
						state_d = named_ok ? SEQ_SCAN : SEQ_DONE;
					end
				end
			end
			SEQ_SCAN: begin
				if (idx_q == end_q) begin
					state_d = SEQ_UPDATE;
				end
			end
			SEQ_UPDATE: state_d = SEQ_DONE;
			SEQ_DONE: begin
				if (out_free) begin
					state_d = SEQ_IDLE;
				end
			end
			default: state_d = SEQ_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = idx_q + 1'b1;
		ram_we    = 1'b0;
		case (state_q)
			SEQ_IDLE: begin
				ram_raddr = (mode == MODE_LEAST) ? first_idx : cpu_idx;
				ram_re    = in_fire && ((mode == MODE_LEAST) ? !range_empty : named_ok);
			end
			SEQ_SCAN: ram_re = (idx_q != end_q);
			SEQ_UPDATE: ram_we = upd_ok;
			default: ram_re = 1'b0;
		endcase
	end

	llcqa_ram #(
		.WIDTH (CNT_W),
		.DEPTH (CPU_COUNT)
	) u_count_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (best_q),
		.wdata (upd_cnt),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SEQ_IDLE;
			valid_q <= '0;
		end else begin
			state_q <= state_d;
			if (ram_we) begin
				valid_q[best_q] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ram_re) begin
			rdv_q <= valid_q[ram_raddr];
		end
		case (state_q)
			SEQ_IDLE: begin
				mode_q  <= mode;
				first_q <= 1'b1;
				if (mode == MODE_LEAST) begin
					idx_q <= first_idx;
					end_q <= eff_last_idx;
				end else begin
					idx_q <= cpu_idx;
					end_q <= cpu_idx;
				end
				res_cpu_q <= (mode == MODE_LEAST) ? 6'd0 : cpu_number;
				res_cnt_q <= 10'd0;
				res_st_q  <= STATUS_RANGE;
			end
			SEQ_SCAN: begin
				first_q <= 1'b0;
				if (take) begin
					best_q     <= idx_q;
					best_cnt_q <= cur_cnt;
				end
				idx_q <= idx_q + 1'b1;
			end
			SEQ_UPDATE: begin
				res_cpu_q <= best_wide[5:0];
				res_cnt_q <= cnt_wide[9:0];
				res_st_q  <= upd_ok ? STATUS_OK : (inc ? STATUS_FULL : STATUS_ZERO);
			end
			default: first_q <= first_q;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == SEQ_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == SEQ_DONE && out_free) begin
			out_cpu_q <= res_cpu_q;
			out_cnt_q <= res_cnt_q;
			out_st_q  <= res_st_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign chosen_cpu = out_cpu_q;
	assign new_count  = out_cnt_q;
	assign status     = out_st_q;

	a_fire_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> (state_q != SEQ_IDLE))
		else $error("accepted word did not start the sequencer");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == SEQ_SCAN) |-> (idx_q <= end_q))
		else $error("scan index ran past the range end");

	a_write_only_update: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == SEQ_UPDATE) && $past(state_q == SEQ_SCAN))
		else $error("count written outside the update step");

	a_full_holds_max: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == SEQ_UPDATE && inc && !upd_ok) |-> (best_cnt_q == CNT_MAX))
		else $error("full status without a full count");

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps

module tb;
	import llcqa_pkg::*;

	localparam int CPU_COUNT     = 64;
	localparam int MAX_QUEUES    = 1023;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int HOLD_CYCLES   = 500;
	localparam int DRAIN_CYCLES  = 80;
	localparam int RANDOM_PHASES = 12;
	localparam int PHASE_WORDS   = 62;

	typedef struct packed {
		logic [5:0] cpu;
		logic [9:0] count;
		logic [1:0] st;
	} assignment_t;

	typedef enum logic [1:0] {
		ROW_PREDICT,
		ROW_TYPED,
		ROW_FIRST,
		ROW_LAST
	} row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		logic [1:0]  op;
		logic [5:0]  arg;
		assignment_t want;
	} row_t;

	localparam int DIRECTED_ROWS = 28;
	localparam row_t DIRECTED [DIRECTED_ROWS] = '{
		'{ROW_TYPED,   MODE_LEAST,  6'd0,  '{6'd0,  10'd1, STATUS_OK}},
		'{ROW_TYPED,   MODE_LEAST,  6'd0,  '{6'd1,  10'd1, STATUS_OK}},
		'{ROW_TYPED,   MODE_ASSIGN, 6'd63, '{6'd63, 10'd1, STATUS_OK}},
		'{ROW_TYPED,   MODE_REMOVE, 6'd63, '{6'd63, 10'd0, STATUS_OK}},
		'{ROW_TYPED,   MODE_REMOVE, 6'd63, '{6'd63, 10'd0, STATUS_ZERO}},
		'{ROW_TYPED,   MODE_UNUSED, 6'd42, '{6'd42, 10'd0, STATUS_RANGE}},
		'{ROW_TYPED,   MODE_UNUSED, 6'd21, '{6'd21, 10'd0, STATUS_RANGE}},
		'{ROW_TYPED,   MODE_ASSIGN, 6'd0,  '{6'd0,  10'd2, STATUS_OK}},
		'{ROW_PREDICT, MODE_LEAST,  6'd0,  '0},
		'{ROW_FIRST,   MODE_LEAST,  6'd40, '0},
		'{ROW_TYPED,   MODE_ASSIGN, 6'd0,  '{6'd0,  10'd0, STATUS_RANGE}},
		'{ROW_TYPED,   MODE_REMOVE, 6'd39, '{6'd39, 10'd0, STATUS_RANGE}},
		'{ROW_TYPED,   MODE_ASSIGN, 6'd40, '{6'd40, 10'd1, STATUS_OK}},
		'{ROW_PREDICT, MODE_LEAST,  6'd0,  '0},
		'{ROW_LAST,    MODE_LEAST,  6'd20, '0},
		'{ROW_TYPED,   MODE_LEAST,  6'd33, '{6'd0,  10'd0, STATUS_RANGE}},
		'{ROW_TYPED,   MODE_ASSIGN, 6'd63, '{6'd63, 10'd0, STATUS_RANGE}},
		'{ROW_TYPED,   MODE_REMOVE, 6'd21, '{6'd21, 10'd0, STATUS_RANGE}},
		'{ROW_FIRST,   MODE_LEAST,  6'd63, '0},
		'{ROW_LAST,    MODE_LEAST,  6'd63, '0},
		'{ROW_TYPED,   MODE_LEAST,  6'd0,  '{6'd63, 10'd1, STATUS_OK}},
		'{ROW_TYPED,   MODE_REMOVE, 6'd63, '{6'd63, 10'd0, STATUS_OK}},
		'{ROW_TYPED,   MODE_ASSIGN, 6'd62, '{6'd62, 10'd0, STATUS_RANGE}},
		'{ROW_FIRST,   MODE_LEAST,  6'd0,  '0},
		'{ROW_LAST,    MODE_LEAST,  6'd0,  '0},
		'{ROW_PREDICT, MODE_LEAST,  6'd0,  '0},
		'{ROW_PREDICT, MODE_REMOVE, 6'd0,  '0},
		'{ROW_LAST,    MODE_LEAST,  6'd63, '0}
	};

	logic        clk        = 1'b0;
	logic        arst_n     = 1'b0;
	logic        in_valid   = 1'b0;
	logic        in_ready;
	logic [1:0]  mode       = MODE_LEAST;
	logic [5:0]  cpu_number = '0;
	logic        out_valid;
	logic        out_ready  = 1'b0;
	logic [5:0]  chosen_cpu;
	logic [9:0]  new_count;
	logic [1:0]  status;
	logic        psel       = 1'b0;
	logic        penable    = 1'b0;
	logic        pwrite     = 1'b0;
	logic [2:0]  paddr      = '0;
	logic [31:0] pwdata     = '0;
	logic [31:0] prdata;
	logic        pready;

	logic [15:0] queue_load [CPU_COUNT];
	logic [5:0]  first_cpu = 6'd0;
	logic [5:0]  last_cpu  = 6'd63;
	assignment_t pending_assignments [$];
	int          mismatches = 0;
	int          burst_left = 0;
	int          cycles     = 0;

	logic [15:0] tick      = '0;
	logic [7:0]  hold_seq  = '0;
	logic [7:0]  hold_seen = '0;
	int          hold_left = 0;

	least_loaded_cpu_queue_assigner_top #(
		.CPU_COUNT         (CPU_COUNT),
		.MAX_QUEUES_PER_CPU(MAX_QUEUES)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.cpu_number(cpu_number),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.chosen_cpu(chosen_cpu),
		.new_count (new_count),
		.status    (status),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always #5 clk = ~clk;

	function automatic assignment_t next_assignment(input logic [1:0] op,
			input logic [5:0] cpu);
		assignment_t r;
		int          target;
		int          best;
		int          i;
		r      = '{cpu: cpu, count: 10'd0, st: STATUS_RANGE};
		target = -1;
		case (op)
			MODE_LEAST: begin
				r.cpu = '0;
				if (first_cpu <= last_cpu) begin
					best = first_cpu;
					for (i = first_cpu + 1; i <= last_cpu; i++)
						if (queue_load[i] < queue_load[best])
							best = i;
					target = best;
				end
			end
			MODE_ASSIGN, MODE_REMOVE: begin
				if (cpu >= first_cpu && cpu <= last_cpu)
					target = cpu;
			end
			default: ;
		endcase
		if (target >= 0) begin
			r.cpu = 6'(target);
			if (op == MODE_REMOVE) begin
				if (queue_load[target] == 0) begin
					r.st = STATUS_ZERO;
				end else begin
					queue_load[target] = queue_load[target] - 1;
					r.st = STATUS_OK;
				end
			end else if (queue_load[target] >= MAX_QUEUES) begin
				r.st = STATUS_FULL;
			end else begin
				queue_load[target] = queue_load[target] + 1;
				r.st = STATUS_OK;
			end
			r.count = 10'(queue_load[target]);
		end
		return r;
	endfunction

	task automatic flag_mismatch(input string what);
		$display("%0t: %s", $time, what);
		mismatches++;
	endtask

	task automatic write_reg(input logic idx, input logic [5:0] value);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= {idx, 2'b00};
		pwdata  <= {26'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		if (idx == REG_RANGE_FIRST)
			first_cpu = value;
		else
			last_cpu = value;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_word(input logic [1:0] op, input logic [5:0] cpu, input bit typed,
			input assignment_t want);
		int          gap;
		assignment_t got;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
				: $urandom_range(1, 10);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid   <= 1'b1;
		mode       <= op;
		cpu_number <= cpu;
		do @(posedge clk); while (in_ready !== 1'b1);
		got = next_assignment(op, cpu);
		pending_assignments.push_back(typed ? want : got);
	endtask

	task automatic quiesce;
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_assignments.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_range(input logic [5:0] lo, input logic [5:0] hi);
		quiesce();
		write_reg(REG_RANGE_FIRST, lo);
		write_reg(REG_RANGE_LAST, hi);
	endtask

	task automatic random_word;
		int         r;
		logic [1:0] op;
		logic [5:0] cpu;
		r = $urandom_range(0, 99);
		if (r < 40)
			op = MODE_LEAST;
		else if (r < 70)
			op = MODE_ASSIGN;
		else if (r < 95)
			op = MODE_REMOVE;
		else
			op = MODE_UNUSED;
		if (first_cpu <= last_cpu && $urandom_range(0, 4) != 0)
			cpu = 6'($urandom_range(last_cpu, first_cpu));
		else
			cpu = 6'($urandom());
		send_word(op, cpu, 1'b0, '0);
	endtask

	always @(posedge clk) begin
		tick <= tick + 1'b1;
		if (hold_seen != hold_seq) begin
			hold_seen <= hold_seq;
			hold_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			case (tick[9:8])
				2'd0: out_ready <= 1'b1;
				2'd1: out_ready <= 1'($urandom_range(0, 1));
				2'd2: out_ready <= ($urandom_range(0, 3) == 0);
				default: out_ready <= (tick[2:0] != 3'd5);
			endcase
		end
	end

	always @(posedge clk) begin
		assignment_t e;
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			if (pending_assignments.size() == 0) begin
				flag_mismatch($sformatf("unexpected word cpu %0d count %0d status %0d",
					chosen_cpu, new_count, status));
			end else begin
				e = pending_assignments.pop_front();
				if (chosen_cpu !== e.cpu)
					flag_mismatch($sformatf("chosen_cpu %0d, want %0d", chosen_cpu, e.cpu));
				if (new_count !== e.count)
					flag_mismatch($sformatf("new_count %0d, want %0d on cpu %0d",
						new_count, e.count, e.cpu));
				if (status !== e.st)
					flag_mismatch($sformatf("status %0d, want %0d on cpu %0d",
						status, e.st, e.cpu));
			end
		end
	end

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("tb NOT OK");
		$finish;
	end

	initial begin
		int         k;
		int         n;
		logic [5:0] lo;
		logic [5:0] hi;
		for (k = 0; k < CPU_COUNT; k++)
			queue_load[k] = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (k = 0; k < DIRECTED_ROWS; k++) begin
			case (DIRECTED[k].kind)
				ROW_FIRST: begin
					quiesce();
					write_reg(REG_RANGE_FIRST, DIRECTED[k].arg);
				end
				ROW_LAST: begin
					quiesce();
					write_reg(REG_RANGE_LAST, DIRECTED[k].arg);
				end
				default: send_word(DIRECTED[k].op, DIRECTED[k].arg,
					DIRECTED[k].kind == ROW_TYPED, DIRECTED[k].want);
			endcase
		end

		for (k = 0; k < RANDOM_PHASES; k++) begin
			case (k)
				0: begin lo = 6'd0;  hi = 6'd63; end
				1: begin lo = 6'd63; hi = 6'd63; end
				2: begin lo = 6'd0;  hi = 6'd0;  end
				3: begin
					lo = 6'd50;
					hi = 6'($urandom_range(0, 49));
				end
				default: begin
					lo = 6'($urandom_range(0, 63));
					if ($urandom_range(0, 3) == 0)
						hi = 6'($urandom_range(0, 63));
					else
						hi = (lo > 6'd56) ? 6'd63 : lo + 6'($urandom_range(0, 7));
				end
			endcase
			set_range(lo, hi);
			if (k == 5)
				hold_seq <= hold_seq + 1'b1;
			for (n = 0; n < PHASE_WORDS; n++)
				random_word();
		end

		in_valid <= 1'b0;
		do @(posedge clk); while (pending_assignments.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule
